// ----- sv/rmrt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_pkg
// Shared types and constants for the RNG monobit and runs health tester.
// ----------------------------------------------------------------------------
package rmrt_pkg;

   localparam int FIELD_W     = 16;   // width of every counter field on the ports
   localparam int DELTA_W     = 7;    // per-word increments, up to 127 bits a word
   localparam int RUN_CLASSES = 6;    // lengths 1..5 and 6 or more
   localparam logic [2:0] RUN_CAP = 3'd6;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register word index, paddr[3:2]
   localparam logic [1:0] REG_SAMPLE_BITS = 2'd0;
   localparam logic [1:0] REG_ONES_LOW    = 2'd1;
   localparam logic [1:0] REG_ONES_HIGH   = 2'd2;

   localparam logic [FIELD_W-1:0] SAMPLE_BITS_RST = 16'd20000;
   localparam logic [FIELD_W-1:0] ONES_LOW_RST    = 16'd9725;
   localparam logic [FIELD_W-1:0] ONES_HIGH_RST   = 16'd10275;

   typedef struct packed {
      logic [FIELD_W-1:0] sample_bits;
      logic [FIELD_W-1:0] ones_low;
      logic [FIELD_W-1:0] ones_high;
   } cfg_type;

   // One classified word, handed from the front end to the counter back end.
   typedef struct packed {
      logic                                 restart;
      logic [DELTA_W-1:0]                   ones_delta;
      logic [RUN_CLASSES-1:0][DELTA_W-1:0]  run_delta;   // runs closed inside the word
      logic [2:0]                           lead_len;    // ones from bit 0, capped at 6
      logic [2:0]                           trail_len;   // ones ending at the last bit
      logic                                 all_ones;    // every examined bit is one
      logic                                 limit;       // sample ends in this word
      logic [FIELD_W-1:0]                   bits_left;
   } entry_type;

endpackage
`default_nettype wire

// ----- sv/rmrt_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_csr
// Configuration registers: sample length and monobit pass bounds.
// ----------------------------------------------------------------------------
module rmrt_csr import rmrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SAMPLE_BITS: cfg_in.sample_bits = csr_pwdata[FIELD_W-1:0];
            REG_ONES_LOW:    cfg_in.ones_low    = csr_pwdata[FIELD_W-1:0];
            REG_ONES_HIGH:   cfg_in.ones_high   = csr_pwdata[FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SAMPLE_BITS: csr_prdata = CSR_DATA_W'(cfg_ff.sample_bits);
         REG_ONES_LOW:    csr_prdata = CSR_DATA_W'(cfg_ff.ones_low);
         REG_ONES_HIGH:   csr_prdata = CSR_DATA_W'(cfg_ff.ones_high);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_bits <= SAMPLE_BITS_RST;
         cfg_ff.ones_low    <= ONES_LOW_RST;
         cfg_ff.ones_high   <= ONES_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/rmrt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_front
// Accepts words, tracks the sample budget and classifies every bit position
// into ones and closed runs by length. The budget stage is registered; the
// classification feeds the queue directly.
// ----------------------------------------------------------------------------
module rmrt_front import rmrt_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [WORD_BITS-1:0] in_word,
   input  logic                 in_restart,
   input  logic [FIELD_W-1:0]   sample_bits,
   input  logic                 full,
   output logic                 push,
   output entry_type            entry
);

   localparam int NB = $clog2(WORD_BITS + 1);

   logic [FIELD_W-1:0]   left_ff, left_in;
   logic                 s1_valid_ff;
   logic [WORD_BITS-1:0] s1_word_ff;
   logic                 s1_restart_ff;
   logic [NB-1:0]        s1_n_ff, n_in;
   logic                 s1_limit_ff, limit_in;
   logic [FIELD_W-1:0]   s1_left_ff;

   logic                 accept;
   logic [FIELD_W-1:0]   base;

   logic [WORD_BITS-1:0] b, vmask, zb, run_end;
   logic [WORD_BITS:0]   bx;
   logic [WORD_BITS+5:0] bp;
   logic [2:0]           rl [WORD_BITS];
   logic [RUN_CLASSES-1:0][WORD_BITS-1:0] cls;
   logic [DELTA_W-1:0]   ones_sum;
   logic [RUN_CLASSES-1:0][DELTA_W-1:0] run_sum;
   logic [2:0]           lead, trail;

   assign push     = s1_valid_ff && !full;
   assign in_ready = !s1_valid_ff || !full;
   assign accept   = in_valid && in_ready;

   // stage 1: take the word's share of the sample budget
   always_comb begin
      base = in_restart ? sample_bits : left_ff;
      if (base < FIELD_W'(WORD_BITS)) begin
         n_in = NB'(base);
      end else begin
         n_in = NB'(WORD_BITS);
      end
      left_in  = base - FIELD_W'(n_in);
      limit_in = (n_in != '0) && (left_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= SAMPLE_BITS_RST;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            left_ff <= left_in;
         end
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff    <= in_word;
         s1_restart_ff <= in_restart;
         s1_n_ff       <= n_in;
         s1_limit_ff   <= limit_in;
         s1_left_ff    <= left_in;
      end
   end

   // stage 2: per-bit run flags, all positions in parallel
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         vmask[i] = NB'(i) < s1_n_ff;
         b[i]     = s1_word_ff[i] && vmask[i];
      end
      bx = {1'b0, b};
      bp = {b, 6'b0};

      // ones ending at bit i, capped at six
      for (int i = 0; i < WORD_BITS; i++) begin
         rl[i] = RUN_CAP;
         for (int k = 5; k >= 0; k--) begin
            if (!bp[i+6-k]) rl[i] = 3'(k);
         end
      end

      // a zero somewhere at or below bit i: the run ending there is not the head run
      for (int i = 0; i < WORD_BITS; i++) begin
         zb[i] = 1'b0;
         for (int j = 0; j < WORD_BITS; j++) begin
            if (j <= i && !b[j]) zb[i] = 1'b1;
         end
      end

      for (int i = 0; i < WORD_BITS; i++) begin
         if (NB'(i + 1) < s1_n_ff) begin
            run_end[i] = b[i] && !bx[i+1];
         end else begin
            run_end[i] = b[i] && s1_limit_ff;
         end
      end

      for (int k = 0; k < RUN_CLASSES; k++) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            cls[k][i] = run_end[i] && zb[i] && (rl[i] == 3'(k + 1));
         end
      end

      ones_sum = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         ones_sum = ones_sum + DELTA_W'(b[i]);
      end
      for (int k = 0; k < RUN_CLASSES; k++) begin
         run_sum[k] = '0;
         for (int i = 0; i < WORD_BITS; i++) begin
            run_sum[k] = run_sum[k] + DELTA_W'(cls[k][i]);
         end
      end

      lead = RUN_CAP;
      for (int k = 5; k >= 0; k--) begin
         if (!b[k]) lead = 3'(k);
      end

      trail = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (NB'(i + 1) == s1_n_ff) trail = rl[i];
      end
   end

   always_comb begin
      entry.restart    = s1_restart_ff;
      entry.ones_delta = ones_sum;
      entry.run_delta  = run_sum;
      entry.lead_len   = lead;
      entry.trail_len  = trail;
      entry.all_ones   = &(b | ~vmask);
      entry.limit      = s1_limit_ff;
      entry.bits_left  = s1_left_ff;
   end

`ifndef ASSERT_OFF
   // the budget only shrinks between restarts
   a_budget_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_restart) |=> (left_ff <= $past(left_ff)))
      else $error("sample budget grew without a restart");
`endif

endmodule
`default_nettype wire

// ----- sv/rmrt_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_fifo
// Short queue of classified words between the front end and the counters.
// ----------------------------------------------------------------------------
module rmrt_fifo import rmrt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type din,
   input  logic      pop,
   output entry_type dout,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;

   assign full  = count_ff == (PTR_W + 1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign dout  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");
`endif

endmodule
`default_nettype wire

// ----- sv/rmrt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmrt_back
// Saturating ones and run counters; closes the run carried across words and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module rmrt_back import rmrt_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  entry_type          entry,
   output logic               pop,
   input  cfg_type            cfg,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [FIELD_W-1:0] ones_count,
   output logic [RUN_CLASSES-1:0][FIELD_W-1:0] runs_count,
   output logic [FIELD_W-1:0] bits_remaining,
   output logic               sample_done,
   output logic               monobit_pass
);

   localparam int CMP_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

   logic                   out_valid_ff, out_valid_in;
   logic [COUNT_WIDTH-1:0] ones_ff, ones_in;
   logic [COUNT_WIDTH-1:0] runs_ff [RUN_CLASSES];
   logic [COUNT_WIDTH-1:0] runs_in [RUN_CLASSES];
   logic [2:0]             open_ff, open_in;
   logic [FIELD_W-1:0]     rem_ff;
   logic                   pass_ff, pass_in;

   logic [2:0]             carry;
   logic [3:0]             head_sum;
   logic [2:0]             head_len;
   logic                   head_close;
   logic [COUNT_WIDTH:0]   ones_sum;
   logic [COUNT_WIDTH:0]   run_sum [RUN_CLASSES];
   logic [DELTA_W:0]       run_add [RUN_CLASSES];

   assign pop          = !empty && (!out_valid_ff || out_ready);
   assign out_valid_in = pop || (out_valid_ff && !out_ready);

   always_comb begin
      carry    = entry.restart ? 3'd0 : open_ff;
      head_sum = {1'b0, carry} + {1'b0, entry.lead_len};
      head_len = (head_sum > 4'(RUN_CAP)) ? RUN_CAP : head_sum[2:0];
      // the carried run closes at the first zero, or at the end of the sample
      head_close = (head_len != '0) && (!entry.all_ones || entry.limit);

      if (entry.limit) begin
         open_in = '0;
      end else if (entry.all_ones) begin
         open_in = head_len;
      end else begin
         open_in = entry.trail_len;
      end

      ones_sum = (entry.restart ? (COUNT_WIDTH + 1)'(0) : {1'b0, ones_ff})
               + (COUNT_WIDTH + 1)'(entry.ones_delta);
      ones_in  = ones_sum[COUNT_WIDTH] ? '1 : ones_sum[COUNT_WIDTH-1:0];

      for (int k = 0; k < RUN_CLASSES; k++) begin
         run_add[k] = {1'b0, entry.run_delta[k]}
                    + (DELTA_W + 1)'(head_close && (head_len == 3'(k + 1)));
         run_sum[k] = (entry.restart ? (COUNT_WIDTH + 1)'(0) : {1'b0, runs_ff[k]})
                    + (COUNT_WIDTH + 1)'(run_add[k]);
         runs_in[k] = run_sum[k][COUNT_WIDTH] ? '1 : run_sum[k][COUNT_WIDTH-1:0];
      end

      pass_in = (entry.bits_left == '0)
             && (CMP_W'(ones_in) > CMP_W'(cfg.ones_low))
             && (CMP_W'(ones_in) < CMP_W'(cfg.ones_high));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         ones_ff      <= '0;
         open_ff      <= '0;
         for (int k = 0; k < RUN_CLASSES; k++) begin
            runs_ff[k] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            ones_ff <= ones_in;
            open_ff <= open_in;
            for (int k = 0; k < RUN_CLASSES; k++) begin
               runs_ff[k] <= runs_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rem_ff  <= entry.bits_left;
         pass_ff <= pass_in;
      end
   end

   assign out_valid      = out_valid_ff;
   assign ones_count     = FIELD_W'(ones_ff);
   assign bits_remaining = rem_ff;
   assign sample_done    = rem_ff == '0;
   assign monobit_pass   = pass_ff;

   always_comb begin
      for (int k = 0; k < RUN_CLASSES; k++) begin
         runs_count[k] = FIELD_W'(runs_ff[k]);
      end
   end

`ifndef ASSERT_OFF
   a_open_capped: assert property (@(posedge clock) disable iff (reset)
      open_ff <= RUN_CAP)
      else $error("open run length beyond cap");

   a_pass_needs_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && pass_ff) |-> (rem_ff == '0))
      else $error("monobit pass before sample complete");

   a_done_no_open_run: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rem_ff == '0) |-> (open_ff == '0))
      else $error("run left open after sample complete");
`endif

endmodule
`default_nettype wire

// ----- sv/rng_monobit_runs_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rng_monobit_runs_test
// RNG health tester: monobit ones count with pass bounds and runs-of-ones
// counts by length, over a configurable number of sample bits.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  req_*     in         generator word (tdata), restart (tuser)
//  rsp_*     out        ones, runs by length, bits remaining (tdata);
//                       sample done, monobit pass (tuser)
//  csr_*     in/out     sample_bits @0x0, ones_low @0x4, ones_high @0x8
//
//  One word a cycle sustained; every bit of a word is classified in parallel.
//  From req beat to rsp beat a word passes the budget stage, the classify
//  stage into a four-entry queue and the counter update into the output
//  register. rsp stalls fill the queue, then drop req_tready.
//  Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module rng_monobit_runs_test import rmrt_pkg::*; #(
   parameter int WORD_BITS   = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // req: word
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((WORD_BITS+7)/8)*8-1:0]    req_tdata,
   // req: restart
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp: ones_count, runs_len1..5, runs_len6_up, bits_remaining
   output logic [8*FIELD_W-1:0]              rsp_tdata,
   // rsp: sample_done, monobit_pass
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]             csr_paddr,
   input  logic [CSR_DATA_W-1:0]             csr_pwdata,
   output logic [CSR_DATA_W-1:0]             csr_prdata,
   output logic                              csr_pready
);

   cfg_type            cfg;
   entry_type          q_din, q_dout;
   logic               q_push, q_pop, q_full, q_empty;
   logic [FIELD_W-1:0] ones_count, bits_remaining;
   logic [RUN_CLASSES-1:0][FIELD_W-1:0] runs_count;
   logic               sample_done, monobit_pass;

   rmrt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rmrt_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_word     (req_tdata[WORD_BITS-1:0]),
      .in_restart  (req_tuser[0]),
      .sample_bits (cfg.sample_bits),
      .full        (q_full),
      .push        (q_push),
      .entry       (q_din)
   );

   rmrt_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   rmrt_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (q_empty),
      .entry          (q_dout),
      .pop            (q_pop),
      .cfg            (cfg),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .ones_count     (ones_count),
      .runs_count     (runs_count),
      .bits_remaining (bits_remaining),
      .sample_done    (sample_done),
      .monobit_pass   (monobit_pass)
   );

   assign rsp_tdata = {bits_remaining, runs_count[5], runs_count[4], runs_count[3],
                       runs_count[2], runs_count[1], runs_count[0], ones_count};
   assign rsp_tuser = {monobit_pass, sample_done};

endmodule
`default_nettype wire
